/* rtl/rth_pkg.sv */
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the RGB to HSV pixel converter
// Payload structs, hue sector codes and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int ChanW      = 8;     // width of one color channel
  localparam int HueW       = 13;    // hue in sixteenths of a degree
  localparam int HueSector  = 960;   // sixty degrees in hue units
  localparam int HueFull    = 5760;  // full circle in hue units
  localparam int DivDw      = 18;    // dividend width, holds 960*255
  localparam int DivQw      = 10;    // quotient width, holds 960

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
    logic             hue_undefined;
  } pixel_out_t;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  // Per-pixel data carried alongside the dividers
  typedef struct packed {
    sector_t          sector;
    logic             neg;     // hue offset is below the sector base
    logic [ChanW-1:0] bright;  // largest channel, also the saturation divisor
    logic [ChanW-1:0] delta;   // max - min, also the hue divisor
  } side_t;

endpackage

/* rtl/rth_front.sv */
// ----------------------------------------------------------------------------
// rth_front: channel compare and dividend scaling
// Two register stages: max/min/sector selection, then constant scaling.
// ----------------------------------------------------------------------------
module rth_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  rth_pkg::pixel_in_t         in_pixel,
  output logic                       out_valid,
  output logic [rth_pkg::DivDw-1:0]  hue_dividend,
  output logic [rth_pkg::DivDw-1:0]  sat_dividend,
  output rth_pkg::side_t             side
);
  import rth_pkg::*;

  logic [ChanW-1:0] mx, mn, abs_diff;
  logic             neg;
  sector_t          sector;

  logic             a_valid_r;
  logic [ChanW-1:0] a_mx_r, a_delta_r, a_abs_r;
  logic             a_neg_r;
  sector_t          a_sector_r;

  logic             b_valid_r;
  logic [DivDw-1:0] b_hue_r, b_sat_r;
  side_t            b_side_r;

  // Stage A: largest channel picks the sector, ties go red, green, blue
  always_comb begin
    mx = (in_pixel.red > in_pixel.green) ? in_pixel.red : in_pixel.green;
    mx = (mx > in_pixel.blue) ? mx : in_pixel.blue;
    mn = (in_pixel.red < in_pixel.green) ? in_pixel.red : in_pixel.green;
    mn = (mn < in_pixel.blue) ? mn : in_pixel.blue;
    if (in_pixel.red >= mx) begin
      sector = SECTOR_RED;
      neg    = in_pixel.green < in_pixel.blue;
      abs_diff = neg ? in_pixel.blue - in_pixel.green : in_pixel.green - in_pixel.blue;
    end else if (in_pixel.green >= mx) begin
      sector = SECTOR_GREEN;
      neg    = in_pixel.blue < in_pixel.red;
      abs_diff = neg ? in_pixel.red - in_pixel.blue : in_pixel.blue - in_pixel.red;
    end else begin
      sector = SECTOR_BLUE;
      neg    = in_pixel.red < in_pixel.green;
      abs_diff = neg ? in_pixel.green - in_pixel.red : in_pixel.red - in_pixel.green;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_mx_r     <= mx;
    a_delta_r  <= mx - mn;
    a_abs_r    <= abs_diff;
    a_neg_r    <= neg;
    a_sector_r <= sector;
  end

  // Stage B: 960*|diff| and 255*delta as shift-and-subtract
  always_ff @(posedge clk) begin
    b_hue_r         <= DivDw'({a_abs_r, 10'b0}) - DivDw'({a_abs_r, 6'b0});
    b_sat_r         <= DivDw'({a_delta_r, 8'b0}) - DivDw'(a_delta_r);
    b_side_r.sector <= a_sector_r;
    b_side_r.neg    <= a_neg_r;
    b_side_r.bright <= a_mx_r;
    b_side_r.delta  <= a_delta_r;
  end

  assign out_valid    = b_valid_r;
  assign hue_dividend = b_hue_r;
  assign sat_dividend = b_sat_r;
  assign side         = b_side_r;

endmodule

/* rtl/rth_divider.sv */
// ----------------------------------------------------------------------------
// rth_divider: pipelined restoring divider
// One quotient bit per stage, an 8-bit divisor, QW registered stages.
// ----------------------------------------------------------------------------
module rth_divider #(
  parameter int DW = rth_pkg::DivDw,
  parameter int QW = rth_pkg::DivQw
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [DW-1:0]             dividend,
  input  logic [rth_pkg::ChanW-1:0] divisor,
  output logic                      out_valid,
  output logic [QW-1:0]             quotient,
  output logic [DW-1:0]             remainder
);
  import rth_pkg::*;

  logic [QW-1:0]    vld_r;
  logic [DW-1:0]    rem_r  [QW];
  logic [QW-1:0]    quo_r  [QW];
  logic [ChanW-1:0] dvs_r  [QW];

  logic             vld_in [QW];
  logic [DW-1:0]    rem_in [QW];
  logic [QW-1:0]    quo_in [QW];
  logic [ChanW-1:0] dvs_in [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Bit = QW - 1 - k;
    logic [DW-1:0] shifted;
    logic          fits;

    if (k == 0) begin : g_head
      assign vld_in[k] = in_valid;
      assign rem_in[k] = dividend;
      assign quo_in[k] = '0;
      assign dvs_in[k] = divisor;
    end else begin : g_link
      assign vld_in[k] = vld_r[k-1];
      assign rem_in[k] = rem_r[k-1];
      assign quo_in[k] = quo_r[k-1];
      assign dvs_in[k] = dvs_r[k-1];
    end

    // Trial subtract of the divisor aligned to this quotient bit
    assign shifted = DW'(dvs_in[k]) << Bit;
    assign fits    = rem_in[k] >= shifted;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= fits ? rem_in[k] - shifted : rem_in[k];
      quo_r[k] <= quo_in[k] | (QW'(fits) << Bit);
      dvs_r[k] <= dvs_in[k];
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quotient  = quo_r[QW-1];
  assign remainder = rem_r[QW-1];

endmodule

/* rtl/rth_back.sv */
// ----------------------------------------------------------------------------
// rth_back: rounding and hue assembly
// Rounds both quotients to nearest, places hue in its sector, registers out.
// ----------------------------------------------------------------------------
module rth_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [rth_pkg::DivQw-1:0] hue_quo,
  input  logic [rth_pkg::DivDw-1:0] hue_rem,
  input  logic [rth_pkg::DivQw-1:0] sat_quo,
  input  logic [rth_pkg::DivDw-1:0] sat_rem,
  input  rth_pkg::side_t            side,
  output logic                      out_valid,
  output rth_pkg::pixel_out_t       out_result
);
  import rth_pkg::*;

  localparam logic [HueW-1:0] BaseGreen = HueW'(2 * HueSector);
  localparam logic [HueW-1:0] BaseBlue  = HueW'(4 * HueSector);
  localparam logic [HueW-1:0] FullTurn  = HueW'(HueFull);

  logic             undef;
  logic             hue_up, sat_up;
  logic [DivQw:0]   offset;
  logic [HueW-1:0]  base, hue;
  logic [ChanW:0]   hue_twice_rem, sat_twice_rem;
  logic [ChanW-1:0] sat;

  logic             valid_r;
  pixel_out_t       result_r;

  always_comb begin
    undef         = side.delta == '0;
    hue_twice_rem = {hue_rem[ChanW-1:0], 1'b0};
    sat_twice_rem = {sat_rem[ChanW-1:0], 1'b0};
    // Halves round up on the signed value: down in magnitude when negative
    hue_up = side.neg ? (hue_twice_rem > {1'b0, side.delta})
                      : (hue_twice_rem >= {1'b0, side.delta});
    offset = {1'b0, hue_quo} + (DivQw+1)'(hue_up);
    case (side.sector)
      SECTOR_RED:   base = '0;
      SECTOR_GREEN: base = BaseGreen;
      SECTOR_BLUE:  base = BaseBlue;
      default:      base = '0;
    endcase
    if (undef) begin
      hue = '0;
    end else if (!side.neg) begin
      hue = base + HueW'(offset);
    end else if (side.sector == SECTOR_RED) begin
      hue = FullTurn - HueW'(offset);  // wrap below zero
    end else begin
      hue = base - HueW'(offset);
    end
    sat_up = sat_twice_rem >= {1'b0, side.bright};
    sat    = (side.bright == '0) ? '0 : sat_quo[ChanW-1:0] + ChanW'(sat_up);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r.hue           <= hue;
    result_r.saturation    <= sat;
    result_r.brightness    <= side.bright;
    result_r.hue_undefined <= undef;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

/* rtl/rgb_to_hsv_pixel.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel: 8-bit RGB to fixed-point HSV pixel converter
// Path from accepted start to out_valid: front stages, divider stages, output register.
// Throughput: one pixel per cycle; busy stays low, set by one quotient bit a stage.
// Reset: synchronous active-low rst_n clears every valid bit; data is not reset.
// The receiver cannot stall: each result shows on out_result for one cycle.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rth_pkg::pixel_in_t   in_pixel,
  output logic                 out_valid,
  output rth_pkg::pixel_out_t  out_result
);
  import rth_pkg::*;

  logic             accept;
  logic             front_valid;
  logic [DivDw-1:0] hue_dividend, sat_dividend;
  side_t            front_side;

  logic             hue_valid, sat_valid;
  logic [DivQw-1:0] hue_quo, sat_quo;
  logic [DivDw-1:0] hue_rem, sat_rem;

  side_t            side_r [DivQw];

  // Every stage advances each cycle, so a new transaction is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Compare channels, pick the sector, scale the dividends.
  rth_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (accept),
    .in_pixel     (in_pixel),
    .out_valid    (front_valid),
    .hue_dividend (hue_dividend),
    .sat_dividend (sat_dividend),
    .side         (front_side)
  );

  // Hue: 960*|diff| / delta. A zero delta yields garbage that the back end drops.
  rth_divider #(
    .DW (DivDw),
    .QW (DivQw)
  ) u_hue_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .dividend  (hue_dividend),
    .divisor   (front_side.delta),
    .out_valid (hue_valid),
    .quotient  (hue_quo),
    .remainder (hue_rem)
  );

  // Saturation: 255*delta / max, same depth so both quotients line up.
  rth_divider #(
    .DW (DivDw),
    .QW (DivQw)
  ) u_sat_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .dividend  (sat_dividend),
    .divisor   (front_side.bright),
    .out_valid (sat_valid),
    .quotient  (sat_quo),
    .remainder (sat_rem)
  );

  // Delay the sector, sign, max and delta to match the divider depth.
  always_ff @(posedge clk) begin
    side_r[0] <= front_side;
    for (int i = 1; i < DivQw; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // Round, place hue in its sector, drive the output register.
  rth_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (hue_valid && sat_valid),
    .hue_quo    (hue_quo),
    .hue_rem    (hue_rem),
    .sat_quo    (sat_quo),
    .sat_rem    (sat_rem),
    .side       (side_r[DivQw-1]),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

/* tb/rgb_to_hsv_pixel_tb.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_tb: self-checking testbench for the RGB to HSV converter
// Drives a directed table of pixels, then shaped random pixels, through the
// start/busy command port with random sender gaps. Every result strobe is
// compared in arrival order against typed-in results or a software HSV predictor.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_tb;

  import rth_pkg::*;

  localparam int NUM_ROWS     = 25;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_ITEMS   = 200;     // final stretch without sender gaps
  localparam int SETTLE_WAIT  = 20;      // pipeline is 13 deep
  localparam int CYCLE_LIMIT  = 400000;

  // One directed row: the pixel, and the result typed in where it is obvious
  typedef struct packed {
    pixel_in_t  pix;
    logic       known;
    pixel_out_t want;
  } pixel_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  pixel_in_t  in_pixel;
  logic       out_valid;
  pixel_out_t out_result;

  pixel_out_t hsv_expected [$];    // predicted results, oldest first
  pixel_out_t hsv_head;
  int         mismatches;
  int         cycle_count;
  int         directed_sent;
  int         random_sent;
  int         results_checked;
  int         undefined_seen;

  pixel_row_t directed_rows [NUM_ROWS] = '{
    // black, white and grays: hue undefined
    '{'{8'd0,   8'd0,   8'd0},   1'b1, '{13'd0,    8'd0,   8'd0,   1'b1}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{13'd0,    8'd0,   8'd255, 1'b1}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{13'd0,    8'd0,   8'd128, 1'b1}},
    '{'{8'd1,   8'd1,   8'd1},   1'b1, '{13'd0,    8'd0,   8'd1,   1'b1}},
    // primaries and secondaries at full scale; ties resolve red, then green
    '{'{8'd255, 8'd0,   8'd0},   1'b1, '{13'd0,    8'd255, 8'd255, 1'b0}},
    '{'{8'd0,   8'd255, 8'd0},   1'b1, '{13'd1920, 8'd255, 8'd255, 1'b0}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{13'd3840, 8'd255, 8'd255, 1'b0}},
    '{'{8'd255, 8'd255, 8'd0},   1'b1, '{13'd960,  8'd255, 8'd255, 1'b0}},
    '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{13'd2880, 8'd255, 8'd255, 1'b0}},
    '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{13'd4800, 8'd255, 8'd255, 1'b0}},
    // primaries at the smallest nonzero level
    '{'{8'd1,   8'd0,   8'd0},   1'b1, '{13'd0,    8'd255, 8'd1,   1'b0}},
    '{'{8'd0,   8'd1,   8'd0},   1'b1, '{13'd1920, 8'd255, 8'd1,   1'b0}},
    '{'{8'd0,   8'd0,   8'd1},   1'b1, '{13'd3840, 8'd255, 8'd1,   1'b0}},
    // hue wrap just below the full circle, and just above zero
    '{'{8'd255, 8'd0,   8'd1},   1'b0, '0},
    '{'{8'd255, 8'd1,   8'd0},   1'b0, '0},
    // exact halves in hue (positive and wrapped) and in saturation
    '{'{8'd128, 8'd1,   8'd0},   1'b0, '0},
    '{'{8'd128, 8'd0,   8'd1},   1'b0, '0},
    '{'{8'd2,   8'd1,   8'd1},   1'b0, '0},
    // near-gray and mixed pixels across the sectors
    '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
    '{'{8'd255, 8'd254, 8'd0},   1'b0, '0},
    '{'{8'd128, 8'd128, 8'd127}, 1'b0, '0},
    '{'{8'd127, 8'd128, 8'd129}, 1'b0, '0},
    '{'{8'd170, 8'd85,  8'd0},   1'b0, '0},
    '{'{8'd85,  8'd170, 8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd128, 8'd255}, 1'b0, '0}
  };

  rgb_to_hsv_pixel DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the HSV result of one pixel in exact integer arithmetic.
  // Hue is base + 960*diff/delta, lifted by a full circle when negative and
  // only then rounded half up; saturation rounds delta*255/max half up.
  function automatic pixel_out_t hsv_of(input pixel_in_t pix);
    int r, g, b, top, bottom, spread, base, diff, num, sat, hue;
    pixel_out_t res;
    r      = pix.red;
    g      = pix.green;
    b      = pix.blue;
    top    = (r > g) ? r : g;
    top    = (top > b) ? top : b;
    bottom = (r < g) ? r : g;
    bottom = (bottom < b) ? bottom : b;
    spread = top - bottom;
    sat    = 0;
    hue    = 0;
    res    = '0;
    if (top > 0) begin
      sat = (2 * spread * 255 + top) / (2 * top);
    end
    if (spread == 0) begin
      res.hue_undefined = 1'b1;
    end else begin
      if (r >= top) begin
        base = 0;
        diff = g - b;
      end else if (g >= top) begin
        base = 2 * HueSector;
        diff = b - r;
      end else begin
        base = 4 * HueSector;
        diff = r - g;
      end
      num = base * spread + HueSector * diff;
      if (num < 0) begin
        num = num + HueFull * spread;
      end
      hue = (2 * num + spread) / (2 * spread);
    end
    res.hue        = hue[HueW-1:0];
    res.saturation = sat[ChanW-1:0];
    res.brightness = top[ChanW-1:0];
    return res;
  endfunction

  // Pick a channel value from the interesting corners of the 8-bit range.
  function automatic logic [ChanW-1:0] edge_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Shape random pixels so that ties, grays, tiny spreads and corner levels
  // come up often; the rest are uniform over the whole cube.
  function automatic pixel_in_t random_pixel();
    pixel_in_t pix;
    int        hi, lo, spread;
    pix = pixel_in_t'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ; // uniform
      4: begin
        pix.green = pix.red;
        pix.blue  = pix.red;
      end
      5: begin
        // two channels share the maximum, the third sits below it
        hi = $urandom_range(1, 255);
        lo = $urandom_range(0, hi - 1);
        case ($urandom_range(0, 2))
          0:       pix = '{hi[7:0], hi[7:0], lo[7:0]};
          1:       pix = '{lo[7:0], hi[7:0], hi[7:0]};
          default: pix = '{hi[7:0], lo[7:0], hi[7:0]};
        endcase
      end
      6: pix = '{edge_level(), edge_level(), edge_level()};
      7: pix = '{8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                 8'($urandom_range(0, 3))};
      8: begin
        // spread of up to one or two below a random level
        hi     = $urandom_range(2, 255);
        spread = $urandom_range(1, 2);
        pix.red   = 8'($urandom_range(hi - spread, hi));
        pix.green = 8'($urandom_range(hi - spread, hi));
        pix.blue  = 8'($urandom_range(hi - spread, hi));
      end
      default: begin
        // one channel on top, the other two tied at the bottom
        hi = $urandom_range(1, 255);
        lo = $urandom_range(0, hi - 1);
        case ($urandom_range(0, 2))
          0:       pix = '{hi[7:0], lo[7:0], lo[7:0]};
          1:       pix = '{lo[7:0], hi[7:0], lo[7:0]};
          default: pix = '{lo[7:0], lo[7:0], hi[7:0]};
        endcase
      end
    endcase
    return pix;
  endfunction

  // Present one pixel and hold it until the block takes it. start stays
  // high across back-to-back transactions; busy is sampled at the edge.
  task automatic send_pixel(input pixel_in_t pix, input pixel_out_t want);
    start    <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (busy);
    hsv_expected.push_back(want);
  endtask

  // Drop start for a burst of cycles and put noise on the idle data bus.
  task automatic idle_sender(input int cycles);
    start    <= 1'b0;
    in_pixel <= pixel_in_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (hsv_expected.size() != 0) @(posedge clk);
  endtask

  // Stimulus: reset, directed table, pause, shaped random pixels, drain.
  initial begin
    int        idle_pct;
    pixel_in_t pix;
    mismatches    = 0;
    directed_sent = 0;
    random_sent   = 0;
    start    <= 1'b0;
    in_pixel <= '0;
    rst_n    <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: use the typed-in result where there is one, else the
    // predictor. A light sprinkle of gaps keeps the sender honest.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        idle_sender($urandom_range(1, 11));
      end
      send_pixel(directed_rows[i].pix,
                 directed_rows[i].known ? directed_rows[i].want
                                        : hsv_of(directed_rows[i].pix));
      directed_sent++;
    end
    drain_results();

    // Random part: the gap rate changes every 64 transactions, including
    // stretches with none, and the final stretch runs at full rate.
    idle_pct = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
        idle_pct = 0;
      end
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        idle_sender($urandom_range(1, 11));
      end
      pix = random_pixel();
      send_pixel(pix, hsv_of(pix));
      random_sent++;
    end

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (hsv_expected.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, hsv_expected.size());
      mismatches++;
    end

    $display("Sent %0d directed and %0d random pixel transactions; checked %0d results.",
             directed_sent, random_sent, results_checked);
    $display("Covered grays, ties, tiny spreads, hue wrap, rounding halves (%0d undefined).",
             undefined_seen);
    if (mismatches == 0) begin
      $display("rgb_to_hsv_pixel verification clean");
    end else begin
      $display("rgb_to_hsv_pixel verification failed");
    end
    $finish;
  end

  // Result checker: every strobe must match the oldest prediction.
  initial begin
    results_checked = 0;
    undefined_seen  = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (hsv_expected.size() == 0) begin
        $display("%0t: unexpected result hue=%0d sat=%0d val=%0d undef=%0b", $time,
                 out_result.hue, out_result.saturation, out_result.brightness,
                 out_result.hue_undefined);
        mismatches++;
      end else begin
        hsv_head = hsv_expected.pop_front();
        results_checked++;
        if (out_result.hue_undefined === 1'b1) begin
          undefined_seen++;
        end
        if (out_result.hue !== hsv_head.hue
            || out_result.saturation !== hsv_head.saturation
            || out_result.brightness !== hsv_head.brightness
            || out_result.hue_undefined !== hsv_head.hue_undefined) begin
          $display("%0t: mismatch exp h=%0d s=%0d v=%0d u=%0b got h=%0d s=%0d v=%0d u=%0b",
                   $time, hsv_head.hue, hsv_head.saturation, hsv_head.brightness,
                   hsv_head.hue_undefined, out_result.hue, out_result.saturation,
                   out_result.brightness, out_result.hue_undefined);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("rgb_to_hsv_pixel verification failed");
      $finish;
    end
  end

endmodule
